// ===== rtl/pnmhp_pkg.sv =====
// ----------------------------------------------------------------------------
// pnmhp_pkg: shared types and constants of the PNM header parser
// Parse phases, status codes, character codes and the word types passed
// between the parser step logic and the top level.
// ----------------------------------------------------------------------------
package pnmhp_pkg;

   localparam int VALUE_BITS_DEFAULT = 16;
   localparam int OUT_BITS           = 16;
   localparam int PHASE_BITS         = 3;
   localparam int STATUS_BITS        = 2;
   localparam int KIND_BITS          = 2;
   localparam int DIGIT_BITS         = 4;
   localparam int DIGIT_BASE         = 10;

   // parse phases
   localparam logic [PHASE_BITS-1:0] PH_MAGIC  = 3'd0;
   localparam logic [PHASE_BITS-1:0] PH_TYPE   = 3'd1;
   localparam logic [PHASE_BITS-1:0] PH_SKIP_W = 3'd2;
   localparam logic [PHASE_BITS-1:0] PH_NUM_W  = 3'd3;
   localparam logic [PHASE_BITS-1:0] PH_SKIP_H = 3'd4;
   localparam logic [PHASE_BITS-1:0] PH_NUM_H  = 3'd5;
   localparam logic [PHASE_BITS-1:0] PH_SKIP_M = 3'd6;
   localparam logic [PHASE_BITS-1:0] PH_NUM_M  = 3'd7;

   // result status
   localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_MAGIC    = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_DIGIT    = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_OVERFLOW = 2'd3;

   localparam logic [KIND_BITS-1:0] KIND_BITMAP = 2'd0;

   // characters
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_4     = 8'h34;
   localparam logic [7:0] CH_6     = 8'h36;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;

   typedef struct packed {
      logic [PHASE_BITS-1:0] phase;
      logic                  in_comment;
      logic [KIND_BITS-1:0]  kind;
   } ctl_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [KIND_BITS-1:0]   image_kind;
      logic [OUT_BITS-1:0]    image_width;
      logic [OUT_BITS-1:0]    image_height;
      logic [OUT_BITS-1:0]    max_value;
   } rsp_type;

endpackage

// ===== rtl/pnmhp_step.sv =====
// ----------------------------------------------------------------------------
// pnmhp_step: one byte of header parsing
// Combinational next-state and result logic for one header byte, applied
// between the input register and the result register of the top level.
// ----------------------------------------------------------------------------
module pnmhp_step #(
   parameter int VALUE_BITS = pnmhp_pkg::VALUE_BITS_DEFAULT
) (
   input  logic [7:0]            item_byte,
   input  logic                  item_eof,
   input  pnmhp_pkg::ctl_type    ctl_q,
   input  logic [VALUE_BITS-1:0] acc_q,
   input  logic [VALUE_BITS-1:0] width_q,
   input  logic [VALUE_BITS-1:0] height_q,
   output pnmhp_pkg::ctl_type    ctl_d,
   output logic [VALUE_BITS-1:0] acc_d,
   output logic [VALUE_BITS-1:0] width_d,
   output logic [VALUE_BITS-1:0] height_d,
   output logic                  emit,
   output pnmhp_pkg::rsp_type    rsp
);

   localparam int SUM_BITS = VALUE_BITS + pnmhp_pkg::DIGIT_BITS;

   logic                                   is_digit;
   logic                                   is_space;
   logic [pnmhp_pkg::DIGIT_BITS-1:0]       digit_val;
   logic [SUM_BITS-1:0]                    acc_sum;
   logic                                   overflow;
   logic                                   run_skip;
   logic [pnmhp_pkg::PHASE_BITS-1:0]       skip_phase;
   logic [pnmhp_pkg::PHASE_BITS-1:0]       num_phase;
   logic [31:0]                            width_ext;
   logic [31:0]                            height_ext;
   logic [31:0]                            acc_ext;

   assign is_digit  = !item_eof && (item_byte >= pnmhp_pkg::CH_0) &&
                      (item_byte <= pnmhp_pkg::CH_9);
   assign is_space  = (item_byte == pnmhp_pkg::CH_SPACE) ||
                      (item_byte == pnmhp_pkg::CH_TAB) ||
                      (item_byte == pnmhp_pkg::CH_NL);
   assign digit_val = pnmhp_pkg::DIGIT_BITS'(item_byte - pnmhp_pkg::CH_0);
   assign acc_sum   = SUM_BITS'(acc_q) * SUM_BITS'(pnmhp_pkg::DIGIT_BASE) +
                      SUM_BITS'(digit_val);
   assign overflow  = acc_sum[SUM_BITS-1:VALUE_BITS] != '0;

   assign width_ext  = 32'(width_q);
   assign height_ext = 32'(height_q);
   assign acc_ext    = 32'(acc_q);

   always_comb begin
      unique case (skip_phase)
         pnmhp_pkg::PH_SKIP_W: num_phase = pnmhp_pkg::PH_NUM_W;
         pnmhp_pkg::PH_SKIP_H: num_phase = pnmhp_pkg::PH_NUM_H;
         default:              num_phase = pnmhp_pkg::PH_NUM_M;
      endcase
   end

   always_comb begin
      ctl_d      = ctl_q;
      acc_d      = acc_q;
      width_d    = width_q;
      height_d   = height_q;
      emit       = 1'b0;
      run_skip   = 1'b0;
      skip_phase = ctl_q.phase;
      rsp        = '0;
      rsp.image_kind = ctl_q.kind;

      unique case (ctl_q.phase)
         pnmhp_pkg::PH_MAGIC: begin
            if (item_eof) begin
               emit       = 1'b1;
               rsp.status = pnmhp_pkg::STATUS_MAGIC;
            end else if (ctl_q.in_comment) begin
               if (item_byte == pnmhp_pkg::CH_NL) ctl_d.in_comment = 1'b0;
            end else if (item_byte == pnmhp_pkg::CH_HASH) begin
               ctl_d.in_comment = 1'b1;
            end else if (item_byte == pnmhp_pkg::CH_P) begin
               ctl_d.phase = pnmhp_pkg::PH_TYPE;
            end else begin
               emit       = 1'b1;
               rsp.status = pnmhp_pkg::STATUS_MAGIC;
            end
         end
         pnmhp_pkg::PH_TYPE: begin
            if (item_eof || item_byte < pnmhp_pkg::CH_4 || item_byte > pnmhp_pkg::CH_6) begin
               emit       = 1'b1;
               rsp.status = pnmhp_pkg::STATUS_MAGIC;
            end else begin
               ctl_d.kind  = pnmhp_pkg::KIND_BITS'(item_byte - pnmhp_pkg::CH_4);
               ctl_d.phase = pnmhp_pkg::PH_SKIP_W;
            end
         end
         pnmhp_pkg::PH_NUM_W, pnmhp_pkg::PH_NUM_H, pnmhp_pkg::PH_NUM_M: begin
            if (is_digit) begin
               if (overflow) begin
                  emit       = 1'b1;
                  rsp.status = pnmhp_pkg::STATUS_OVERFLOW;
               end else begin
                  acc_d = acc_sum[VALUE_BITS-1:0];
               end
            end else if (ctl_q.phase == pnmhp_pkg::PH_NUM_W) begin
               // terminator byte goes on to the skip logic
               width_d    = acc_q;
               run_skip   = 1'b1;
               skip_phase = pnmhp_pkg::PH_SKIP_H;
            end else if (ctl_q.phase == pnmhp_pkg::PH_NUM_H) begin
               height_d = acc_q;
               if (ctl_q.kind == pnmhp_pkg::KIND_BITMAP) begin
                  emit             = 1'b1;
                  rsp.status       = pnmhp_pkg::STATUS_OK;
                  rsp.image_width  = width_ext[pnmhp_pkg::OUT_BITS-1:0];
                  rsp.image_height = acc_ext[pnmhp_pkg::OUT_BITS-1:0];
               end else begin
                  run_skip   = 1'b1;
                  skip_phase = pnmhp_pkg::PH_SKIP_M;
               end
            end else begin
               emit             = 1'b1;
               rsp.status       = pnmhp_pkg::STATUS_OK;
               rsp.image_width  = width_ext[pnmhp_pkg::OUT_BITS-1:0];
               rsp.image_height = height_ext[pnmhp_pkg::OUT_BITS-1:0];
               rsp.max_value    = acc_ext[pnmhp_pkg::OUT_BITS-1:0];
            end
         end
         default: begin
            run_skip = 1'b1;
         end
      endcase

      if (run_skip) begin
         ctl_d.phase = skip_phase;
         if (item_eof) begin
            emit       = 1'b1;
            rsp.status = pnmhp_pkg::STATUS_DIGIT;
         end else if (ctl_q.in_comment) begin
            if (item_byte == pnmhp_pkg::CH_NL) ctl_d.in_comment = 1'b0;
         end else if (is_space) begin
            ctl_d.in_comment = 1'b0;
         end else if (item_byte == pnmhp_pkg::CH_HASH) begin
            ctl_d.in_comment = 1'b1;
         end else if (is_digit) begin
            acc_d       = VALUE_BITS'(digit_val);
            ctl_d.phase = num_phase;
         end else begin
            emit       = 1'b1;
            rsp.status = pnmhp_pkg::STATUS_DIGIT;
         end
      end

      // any result returns the parser to its start state
      if (emit) begin
         ctl_d    = '0;
         acc_d    = '0;
         width_d  = '0;
         height_d = '0;
      end
   end

endmodule

// ===== rtl/netpbm_header_parser_unit.sv =====
// Result: registered when the byte that ends the header advances out of the input register.
// Throughput: one byte per cycle; the input register advances whenever the result register
// is empty or its word is being taken. While a result word waits unread the input register
// holds and only one more byte is accepted.
// Reset: synchronous, active high; clears the parse state, input and result valid flags.
// ----------------------------------------------------------------------------
// netpbm_header_parser_unit: PNM header parser
// Parses magic, type, width, height and, except for bitmaps, maximum value from a byte stream
// and returns one status word per header.
// ----------------------------------------------------------------------------
module netpbm_header_parser_unit #(
   parameter int VALUE_BITS = pnmhp_pkg::VALUE_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_file,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [1:0]  rsp_image_kind,
   output logic [15:0] rsp_image_width,
   output logic [15:0] rsp_image_height,
   output logic [15:0] rsp_max_value
);

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff;
   logic                  in_eof_ff;
   pnmhp_pkg::ctl_type    ctl_ff, ctl_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [VALUE_BITS-1:0] width_ff, width_in;
   logic [VALUE_BITS-1:0] height_ff, height_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   pnmhp_pkg::rsp_type    rsp_ff;
   pnmhp_pkg::rsp_type    step_rsp;
   logic                  step_emit;
   logic                  advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   pnmhp_step #(
      .VALUE_BITS (VALUE_BITS)
   ) u_step (
      .item_byte (in_byte_ff),
      .item_eof  (in_eof_ff),
      .ctl_q     (ctl_ff),
      .acc_q     (acc_ff),
      .width_q   (width_ff),
      .height_q  (height_ff),
      .ctl_d     (ctl_in),
      .acc_d     (acc_in),
      .width_d   (width_in),
      .height_d  (height_in),
      .emit      (step_emit),
      .rsp       (step_rsp)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (advance) in_valid_in = 1'b0;
      if (req_valid && req_ready) in_valid_in = 1'b1;

      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (advance && step_emit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ctl_ff       <= '0;
         acc_ff       <= '0;
         width_ff     <= '0;
         height_ff    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            ctl_ff    <= ctl_in;
            acc_ff    <= acc_in;
            width_ff  <= width_in;
            height_ff <= height_in;
         end
      end
   end

   // payload registers: load without reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_eof_ff  <= req_end_of_file;
      end
      if (advance && step_emit) rsp_ff <= step_rsp;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_image_kind   = rsp_ff.image_kind;
   assign rsp_image_width  = rsp_ff.image_width;
   assign rsp_image_height = rsp_ff.image_height;
   assign rsp_max_value    = rsp_ff.max_value;

   a_emit_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      advance && step_emit |=> rsp_valid_ff)
      else $error("result word lost after emit");

   a_emit_clears_state: assert property (@(posedge clock) disable iff (reset)
      advance && step_emit |=> ctl_ff.phase == pnmhp_pkg::PH_MAGIC &&
                               !ctl_ff.in_comment && acc_ff == '0)
      else $error("parser not back at start after result");

   a_error_zero_values: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != pnmhp_pkg::STATUS_OK |->
         rsp_ff.image_width == '0 && rsp_ff.image_height == '0 &&
         rsp_ff.max_value == '0)
      else $error("error word carries values");

   a_comment_phase: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.in_comment |-> ctl_ff.phase == pnmhp_pkg::PH_MAGIC ||
         ctl_ff.phase == pnmhp_pkg::PH_SKIP_W || ctl_ff.phase == pnmhp_pkg::PH_SKIP_H ||
         ctl_ff.phase == pnmhp_pkg::PH_SKIP_M)
      else $error("comment flag set outside a skip phase");

   a_bitmap_no_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.image_kind == pnmhp_pkg::KIND_BITMAP |->
         rsp_ff.max_value == '0)
      else $error("bitmap word carries a maximum value");

endmodule

// ===== sim/tb_netpbm_header_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_netpbm_header_parser_unit: self-checking bench for the PNM header parser
// Streams header bytes through the request channel and predicts the status
// word that each header produces. Every result word is checked field by
// field against the prediction. The run covers directed corner cases, random
// well-formed and broken headers, noise, several idle and stall mixes, and a
// long receiver hold-off that backs the parser up.
// ----------------------------------------------------------------------------
module tb_netpbm_header_parser_unit;

   localparam int VALUE_BITS   = 16;
   localparam int HOLD_CYCLES  = 400;
   localparam int STUCK_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [7:0] CH_5 = pnmhp_pkg::CH_4 + 8'd1;
   localparam logic [7:0] CH_X = 8'h78;

   typedef struct {
      logic [7:0] data;
      bit         eof;
      int         idle_pct;
      int         stall_pct;
      bit         hold;
   } stream_word_type;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte   = '0;
   logic        req_end_of_file = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready       = 1'b0;
   logic [1:0]  rsp_status;
   logic [1:0]  rsp_image_kind;
   logic [15:0] rsp_image_width;
   logic [15:0] rsp_image_height;
   logic [15:0] rsp_max_value;

   stream_word_type    header_bytes[$];
   pnmhp_pkg::rsp_type header_results[$];

   int gen_idle      = 0;
   int gen_stall     = 0;
   bit gen_hold      = 1'b0;
   int rsp_stall_pct = 0;
   bit hold_request  = 1'b0;
   bit hold_done     = 1'b0;
   int hold_left     = 0;
   int stuck_cycles  = 0;
   int error_count   = 0;

   // parser state as the bench sees it
   logic [pnmhp_pkg::PHASE_BITS-1:0] hdr_phase      = pnmhp_pkg::PH_MAGIC;
   bit                               hdr_in_comment = 1'b0;
   int unsigned                      hdr_acc        = 0;
   int unsigned                      hdr_width      = 0;
   int unsigned                      hdr_height     = 0;
   logic [pnmhp_pkg::KIND_BITS-1:0]  hdr_kind       = '0;

   netpbm_header_parser_unit #(
      .VALUE_BITS(VALUE_BITS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_end_of_file  (req_end_of_file),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_image_kind   (rsp_image_kind),
      .rsp_image_width  (rsp_image_width),
      .rsp_image_height (rsp_image_height),
      .rsp_max_value    (rsp_max_value)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // header prediction
   // ------------------------------------------------------------------------
   function automatic void clear_header();
      hdr_phase      = pnmhp_pkg::PH_MAGIC;
      hdr_in_comment = 1'b0;
      hdr_acc        = 0;
      hdr_width      = 0;
      hdr_height     = 0;
      hdr_kind       = '0;
   endfunction

   function automatic bit close_header(input logic [pnmhp_pkg::STATUS_BITS-1:0] status,
                                       input int unsigned w, input int unsigned h,
                                       input int unsigned m,
                                       output pnmhp_pkg::rsp_type word);
      word.status       = status;
      word.image_kind   = hdr_kind;
      word.image_width  = w[pnmhp_pkg::OUT_BITS-1:0];
      word.image_height = h[pnmhp_pkg::OUT_BITS-1:0];
      word.max_value    = m[pnmhp_pkg::OUT_BITS-1:0];
      clear_header();
      return 1'b1;
   endfunction

   // Advance the header state by one byte; return 1 when a status word falls out.
   function automatic bit parse_byte(input logic [7:0] b, input bit eof,
                                     output pnmhp_pkg::rsp_type word);
      bit                is_digit;
      longint unsigned   v;
      longint unsigned   value_limit;
      is_digit    = !eof && b >= pnmhp_pkg::CH_0 && b <= pnmhp_pkg::CH_9;
      value_limit = (64'd1 << VALUE_BITS) - 1;
      word        = '0;

      if (hdr_phase == pnmhp_pkg::PH_MAGIC) begin
         if (eof)
            return close_header(pnmhp_pkg::STATUS_MAGIC, 0, 0, 0, word);
         if (hdr_in_comment) begin
            if (b == pnmhp_pkg::CH_NL)
               hdr_in_comment = 1'b0;
            return 1'b0;
         end
         if (b == pnmhp_pkg::CH_HASH)
            hdr_in_comment = 1'b1;
         else if (b == pnmhp_pkg::CH_P)
            hdr_phase = pnmhp_pkg::PH_TYPE;
         else
            return close_header(pnmhp_pkg::STATUS_MAGIC, 0, 0, 0, word);
         return 1'b0;
      end

      if (hdr_phase == pnmhp_pkg::PH_TYPE) begin
         if (eof || b < pnmhp_pkg::CH_4 || b > pnmhp_pkg::CH_6)
            return close_header(pnmhp_pkg::STATUS_MAGIC, 0, 0, 0, word);
         hdr_kind  = pnmhp_pkg::KIND_BITS'(b - pnmhp_pkg::CH_4);
         hdr_phase = pnmhp_pkg::PH_SKIP_W;
         return 1'b0;
      end

      if (hdr_phase == pnmhp_pkg::PH_NUM_W || hdr_phase == pnmhp_pkg::PH_NUM_H ||
          hdr_phase == pnmhp_pkg::PH_NUM_M) begin
         if (is_digit) begin
            v = longint'(hdr_acc) * pnmhp_pkg::DIGIT_BASE + (b - pnmhp_pkg::CH_0);
            if (v > value_limit)
               return close_header(pnmhp_pkg::STATUS_OVERFLOW, 0, 0, 0, word);
            hdr_acc = int'(v);
            return 1'b0;
         end
         if (hdr_phase == pnmhp_pkg::PH_NUM_W) begin
            hdr_width = hdr_acc;
            hdr_phase = pnmhp_pkg::PH_SKIP_H;
         end else if (hdr_phase == pnmhp_pkg::PH_NUM_H) begin
            hdr_height = hdr_acc;
            if (hdr_kind == pnmhp_pkg::KIND_BITMAP)
               return close_header(pnmhp_pkg::STATUS_OK, hdr_width, hdr_height, 0, word);
            hdr_phase = pnmhp_pkg::PH_SKIP_M;
         end else begin
            return close_header(pnmhp_pkg::STATUS_OK, hdr_width, hdr_height, hdr_acc,
                                word);
         end
         // the terminator falls through to the skip rules below
      end

      if (eof)
         return close_header(pnmhp_pkg::STATUS_DIGIT, 0, 0, 0, word);
      if (hdr_in_comment) begin
         if (b == pnmhp_pkg::CH_NL)
            hdr_in_comment = 1'b0;
         return 1'b0;
      end
      if (b == pnmhp_pkg::CH_SPACE || b == pnmhp_pkg::CH_TAB || b == pnmhp_pkg::CH_NL)
         return 1'b0;
      if (b == pnmhp_pkg::CH_HASH) begin
         hdr_in_comment = 1'b1;
         return 1'b0;
      end
      if (is_digit) begin
         hdr_acc = b - pnmhp_pkg::CH_0;
         case (hdr_phase)
            pnmhp_pkg::PH_SKIP_W: hdr_phase = pnmhp_pkg::PH_NUM_W;
            pnmhp_pkg::PH_SKIP_H: hdr_phase = pnmhp_pkg::PH_NUM_H;
            default:              hdr_phase = pnmhp_pkg::PH_NUM_M;
         endcase
         return 1'b0;
      end
      return close_header(pnmhp_pkg::STATUS_DIGIT, 0, 0, 0, word);
   endfunction

   // ------------------------------------------------------------------------
   // stimulus building
   // ------------------------------------------------------------------------
   task automatic put_word(input logic [7:0] data, input bit eof);
      stream_word_type w;
      w.data      = data;
      w.eof       = eof;
      w.idle_pct  = gen_idle;
      w.stall_pct = gen_stall;
      w.hold      = gen_hold;
      gen_hold    = 1'b0;
      header_bytes.push_back(w);
   endtask

   task automatic put_byte(input logic [7:0] data);
      put_word(data, 1'b0);
   endtask

   task automatic put_eof();
      put_word(8'($urandom_range(255)), 1'b1);
   endtask

   task automatic put_comment();
      logic [7:0] c;
      put_byte(pnmhp_pkg::CH_HASH);
      repeat ($urandom_range(6)) begin
         c = 8'($urandom_range(255));
         if (c == pnmhp_pkg::CH_NL)
            c = pnmhp_pkg::CH_SPACE;
         put_byte(c);
      end
      put_byte(pnmhp_pkg::CH_NL);
   endtask

   task automatic put_blank(input bit need_one);
      int n;
      n = need_one ? $urandom_range(3, 1) : $urandom_range(2);
      repeat (n) begin
         case ($urandom_range(3))
            0:       put_byte(pnmhp_pkg::CH_SPACE);
            1:       put_byte(pnmhp_pkg::CH_TAB);
            2:       put_byte(pnmhp_pkg::CH_NL);
            default: put_comment();
         endcase
      end
   endtask

   task automatic put_number(input int unsigned v, input bit pad);
      string s;
      if (pad && $urandom_range(9) == 0)
         repeat ($urandom_range(2, 1)) put_byte(pnmhp_pkg::CH_0);
      s = $sformatf("%0d", v);
      for (int i = 0; i < s.len(); i++)
         put_byte(s[i]);
   endtask

   function automatic int unsigned pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 30) return $urandom_range(9);
      if (r < 60) return $urandom_range(999, 10);
      if (r < 80) return $urandom_range(65535, 1000);
      if (r < 88) return 65535;
      if (r < 92) return 0;
      return $urandom_range(999999, 65536);
   endfunction

   function automatic logic [7:0] pick_non_digit();
      logic [7:0] c;
      do
         c = 8'($urandom_range(255));
      while (c >= pnmhp_pkg::CH_0 && c <= pnmhp_pkg::CH_9);
      return c;
   endfunction

   // Well-formed header with random content; some get cut short or get one byte trashed.
   task automatic put_header();
      int first;
      int kind;
      int r;
      int cut;
      first = header_bytes.size();
      if ($urandom_range(3) == 0)
         repeat ($urandom_range(2, 1)) put_comment();
      kind = $urandom_range(2);
      put_byte(pnmhp_pkg::CH_P);
      put_byte(pnmhp_pkg::CH_4 + 8'(kind));
      put_blank(1'b0);
      put_number(pick_value(), 1'b1);
      put_blank(1'b1);
      put_number(pick_value(), 1'b1);
      if (kind != pnmhp_pkg::KIND_BITMAP) begin
         put_blank(1'b1);
         put_number(pick_value(), 1'b1);
      end
      if ($urandom_range(99) < 40)
         put_eof();
      else
         put_byte(pick_non_digit());

      r = $urandom_range(99);
      if (r < 8) begin
         cut = $urandom_range(header_bytes.size() - 1, first);
         while (header_bytes.size() > cut)
            void'(header_bytes.pop_back());
         if ($urandom_range(1))
            put_eof();
      end else if (r < 15) begin
         cut = $urandom_range(header_bytes.size() - 1, first);
         header_bytes[cut].data = 8'($urandom_range(255));
         header_bytes[cut].eof  = 1'b0;
      end
   endtask

   task automatic put_noise();
      repeat ($urandom_range(4, 1)) begin
         case ($urandom_range(5))
            0:       put_eof();
            1:       put_byte(pnmhp_pkg::CH_P);
            2:       put_byte(pnmhp_pkg::CH_HASH);
            3:       put_byte(pnmhp_pkg::CH_0 + 8'($urandom_range(9)));
            default: put_byte(8'($urandom_range(255)));
         endcase
      end
   endtask

   // Short error words keep results coming fast so a held receiver backs the parser up.
   task automatic put_stray();
      logic [7:0] c;
      if ($urandom_range(4) == 0) begin
         put_eof();
      end else begin
         do
            c = 8'($urandom_range(255));
         while (c == pnmhp_pkg::CH_P || c == pnmhp_pkg::CH_HASH);
         put_byte(c);
      end
   endtask

   task automatic fill_phase(input int n, input int idle, input int stall, input bit squeeze);
      int stop;
      stop      = header_bytes.size() + n;
      gen_idle  = idle;
      gen_stall = stall;
      while (header_bytes.size() < stop) begin
         if (squeeze)
            put_stray();
         else if ($urandom_range(99) < 85)
            put_header();
         else
            put_noise();
      end
   endtask

   // ------------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------------
   task automatic report_error(input string msg);
      $display("ERROR %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got)
         report_error($sformatf("%s expected %0d got %0d", name, want, got));
   endtask

   // ------------------------------------------------------------------------
   // driver, receiver, hold-off, monitor, watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : drive_bytes
      stream_word_type    w;
      pnmhp_pkg::rsp_type word;
      if (reset) begin
         req_valid <= 1'b0;
         clear_header();
      end else begin
         if (req_valid && req_ready) begin
            if (parse_byte(req_data_byte, req_end_of_file, word))
               header_results.push_back(word);
         end
         // hold the word until it is taken, then offer the next one or idle
         if (!req_valid || req_ready) begin
            if (header_bytes.size() != 0 && $urandom_range(99) >= header_bytes[0].idle_pct) begin
               w = header_bytes.pop_front();
               req_valid       <= 1'b1;
               req_data_byte   <= w.data;
               req_end_of_file <= w.eof;
               rsp_stall_pct   <= w.stall_pct;
               hold_request    <= w.hold;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      pnmhp_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (header_results.size() == 0) begin
            report_error($sformatf("result word with none pending, status %0d", rsp_status));
         end else begin
            want = header_results.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("image_kind", want.image_kind, rsp_image_kind);
            check_field("image_width", want.image_width, rsp_image_width);
            check_field("image_height", want.image_height, rsp_image_height);
            check_field("max_value", want.max_value, rsp_max_value);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == STUCK_LIMIT) begin
         $display("ERROR %0t: no word moved for %0d cycles", $time, STUCK_LIMIT);
         $display("FAIL netpbm_header_parser_unit");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      // end of file before any magic
      put_eof();
      // bad type digit
      put_byte(pnmhp_pkg::CH_P);
      put_byte(8'hFF);
      // end of file where the width should start
      put_byte(pnmhp_pkg::CH_P);
      put_byte(pnmhp_pkg::CH_6);
      put_eof();
      // leading comment, bitmap without a maximum, extreme sizes, ended by end of file
      put_byte(pnmhp_pkg::CH_HASH);
      put_byte(pnmhp_pkg::CH_NL);
      put_byte(pnmhp_pkg::CH_P);
      put_byte(pnmhp_pkg::CH_4);
      put_number(0, 1'b0);
      put_byte(pnmhp_pkg::CH_SPACE);
      put_number(65535, 1'b0);
      put_eof();
      // comment and tab between numbers, ended by one stray byte
      put_byte(pnmhp_pkg::CH_P);
      put_byte(CH_5);
      put_number(0, 1'b0);
      put_byte(pnmhp_pkg::CH_HASH);
      put_byte(pnmhp_pkg::CH_NL);
      put_number(1, 1'b0);
      put_byte(pnmhp_pkg::CH_TAB);
      put_number(7, 1'b0);
      put_byte(CH_X);
      // width one past the limit
      put_byte(pnmhp_pkg::CH_P);
      put_byte(pnmhp_pkg::CH_6);
      put_number(65536, 1'b0);

      fill_phase(280, 0, 0, 1'b0);
      fill_phase(250, 80, 0, 1'b0);
      fill_phase(250, 0, 80, 1'b0);
      fill_phase(250, 35, 35, 1'b0);
      gen_hold = 1'b1;
      fill_phase(100, 0, 0, 1'b1);
      fill_phase(190, 20, 20, 1'b0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (header_bytes.size() != 0 || req_valid)
         @(posedge clock);
      while (header_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("PASS netpbm_header_parser_unit");
      else
         $display("FAIL netpbm_header_parser_unit");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/pnmhp_pkg.sv
rtl/pnmhp_step.sv
rtl/netpbm_header_parser_unit.sv
sim/tb_netpbm_header_parser_unit.sv
